// File: hdl/rrtr_pkg.sv
// Shared types and codes of the round-robin task ring.
package rrtr_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
    localparam logic [1:0] ST_TICK_IGNORED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_NEXT,
        S_TICK_ID,
        S_ADD_SCAN,
        S_ADD_LINK,
        S_REM_CMP,
        S_REM_UNLINK,
        S_REM_CURID
    } state_t;

    // write enables of the three ring memories
    typedef struct packed {
        logic id_we;
        logic next_we;
        logic prev_we;
    } mem_we_t;

endpackage

// File: hdl/rrtr_ring_mem.sv
// Ring storage: task ids and forward and backward links, one shared read address.
module rrtr_ring_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  rrtr_pkg::mem_we_t we,
    input  logic [AW-1:0]     id_waddr,
    input  logic [31:0]       id_wdata,
    input  logic [AW-1:0]     next_waddr,
    input  logic [AW-1:0]     next_wdata,
    input  logic [AW-1:0]     prev_waddr,
    input  logic [AW-1:0]     prev_wdata,
    input  logic [AW-1:0]     raddr,
    output logic [31:0]       rd_id,
    output logic [AW-1:0]     rd_next,
    output logic [AW-1:0]     rd_prev
);
    import rrtr_pkg::*;

    logic [31:0]   id_mem   [DEPTH];
    logic [AW-1:0] next_mem [DEPTH];
    logic [AW-1:0] prev_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        rd_id <= id_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        rd_next <= next_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        rd_prev <= prev_mem[raddr];
    end

endmodule

// File: hdl/round_robin_task_ring_unit.sv
// Top level of the round-robin task ring: command sequencer and ring state.
//
// Usage:
//  - Request channel (in_valid / in_stall, cmd, task_id): one command per
//    request; in_stall is high while a command is being worked on and while
//    the previous result still waits in the output register.
//  - Result channel (out_valid / out_stall): one result per request with the
//    current task, a status code and the task count, from an output register.
//  - Config channel (cfg_valid / cfg_ready, cfg_data): sched_active bit,
//    always ready. Write it only while the block is idle.
// Steps per request, up to the result load:
//  - tick: no read (ignored, first tick, empty ring) or advance, two reads
//  - add: free map scan to the lowest free slot, one slot a cycle, then a
//    link step unless the ring was empty; full ring refused
//  - remove: walk from the head, one entry a cycle on the single memory
//    read port, then unlink; the successor's id is fetched when the
//    current task is removed; a miss walks the whole ring; empty ring refused
// The next request can be taken once the result is loaded, unless the
// result is stalled. Reset empties the ring (free map all ones), clears current,
// the begun flag and sched_active; the ring memories need no clearing.
module round_robin_task_ring_unit #(
    parameter int MAX_TASKS = 16,
    localparam int SW = $clog2(MAX_TASKS),
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    // config write
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    // request channel
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    cmd,
    input  logic [31:0]   task_id,
    // result channel
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   running_id,
    output logic          running_valid,
    output logic [1:0]    status,
    output logic [CW-1:0] task_count
);
    import rrtr_pkg::*;

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

    state_t state_reg, state_next;
    logic active_reg, active_next;
    logic begun_reg, begun_next;
    logic present_reg, present_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [31:0] cur_id_reg, cur_id_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [MAX_TASKS-1:0] free_reg, free_next;
    // scan index on add, walk pointer / found slot on remove
    logic [SW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] nx_reg, nx_next;
    logic [SW-1:0] pv_reg, pv_next;
    logic [31:0] id_reg, id_next;
    logic [1:0] st_reg, st_next;

    logic out_valid_reg, out_valid_next;
    logic [31:0] out_id_reg, out_id_next;
    logic out_run_reg, out_run_next;
    logic [1:0] out_st_reg, out_st_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;

    mem_we_t mem_we;
    logic [SW-1:0] id_waddr, next_waddr, next_wdata, prev_waddr, prev_wdata, raddr;
    logic [31:0] id_wdata;
    logic [31:0] rd_id;
    logic [SW-1:0] rd_next, rd_prev;
    logic finish;
    logic out_free;

    rrtr_ring_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (SW)
    ) u_mem (
        .clk        (clk),
        .we         (mem_we),
        .id_waddr   (id_waddr),
        .id_wdata   (id_wdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .raddr      (raddr),
        .rd_id      (rd_id),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev)
    );

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != S_IDLE) || !out_free;
    assign out_valid     = out_valid_reg;
    assign running_id    = out_id_reg;
    assign running_valid = out_run_reg;
    assign status        = out_st_reg;
    assign task_count    = out_cnt_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            begun_reg     <= 1'b0;
            present_reg   <= 1'b0;
            cur_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            begun_reg     <= begun_next;
            present_reg   <= present_next;
            cur_reg       <= cur_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_id_reg  <= cur_id_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        nx_reg      <= nx_next;
        pv_reg      <= pv_next;
        id_reg      <= id_next;
        st_reg      <= st_next;
        out_id_reg  <= out_id_next;
        out_run_reg <= out_run_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        begun_next   = begun_reg;
        present_next = present_reg;
        cur_next     = cur_reg;
        cur_id_next  = cur_id_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        nx_next      = nx_reg;
        pv_next      = pv_reg;
        id_next      = id_reg;
        st_next      = st_reg;
        finish       = 1'b0;

        mem_we     = '0;
        id_waddr   = idx_reg;
        id_wdata   = id_reg;
        next_waddr = idx_reg;
        next_wdata = idx_reg;
        prev_waddr = idx_reg;
        prev_wdata = idx_reg;
        raddr      = idx_reg;

        if (cfg_valid)
        begin
            active_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    id_next = task_id;
                    st_next = ST_OK;
                    case (cmd)
                        CMD_TICK:
                        begin
                            if (!active_reg)
                            begin
                                st_next = ST_TICK_IGNORED;
                                finish  = 1'b1;
                            end
                            else if (!begun_reg)
                            begin
                                begun_next = 1'b1;
                                finish     = 1'b1;
                            end
                            else if (!present_reg)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                raddr      = cur_reg;
                                state_next = S_TICK_NEXT;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                st_next = ST_FULL;
                                finish  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_ADD_SCAN;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_NOT_FOUND;
                                finish  = 1'b1;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                idx_next   = head_reg;
                                n_next     = '0;
                                state_next = S_REM_CMP;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_TICK_NEXT:
            begin
                cur_next   = rd_next;
                raddr      = rd_next;
                state_next = S_TICK_ID;
            end
            S_TICK_ID:
            begin
                raddr       = cur_reg;
                cur_id_next = rd_id;
                finish      = 1'b1;
            end
            S_ADD_SCAN:
            begin
                if (free_reg[idx_reg])
                begin
                    mem_we.id_we       = 1'b1;
                    mem_we.next_we     = 1'b1;
                    mem_we.prev_we     = 1'b1;
                    free_next[idx_reg] = 1'b0;
                    count_next         = count_reg + 1'b1;
                    if (!present_reg)
                    begin
                        present_next = 1'b1;
                        cur_next     = idx_reg;
                        cur_id_next  = id_reg;
                    end
                    if (count_reg == '0)
                    begin
                        // first entry links to itself
                        head_next = idx_reg;
                        tail_next = idx_reg;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        next_wdata = head_reg;
                        prev_wdata = tail_reg;
                        state_next = S_ADD_LINK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ADD_LINK:
            begin
                mem_we.next_we = 1'b1;
                mem_we.prev_we = 1'b1;
                next_waddr     = tail_reg;
                prev_waddr     = head_reg;
                tail_next      = idx_reg;
                finish         = 1'b1;
            end
            S_REM_CMP:
            begin
                if (rd_id == id_reg)
                begin
                    nx_next    = rd_next;
                    pv_next    = rd_prev;
                    state_next = S_REM_UNLINK;
                end
                else if (n_reg + 1'b1 == count_reg)
                begin
                    st_next = ST_NOT_FOUND;
                    finish  = 1'b1;
                end
                else
                begin
                    n_next   = n_reg + 1'b1;
                    idx_next = rd_next;
                    raddr    = rd_next;
                end
            end
            S_REM_UNLINK:
            begin
                free_next[idx_reg] = 1'b1;
                count_next         = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    present_next = 1'b0;
                    cur_next     = '0;
                    head_next    = '0;
                    tail_next    = '0;
                    finish       = 1'b1;
                end
                else
                begin
                    mem_we.next_we = 1'b1;
                    mem_we.prev_we = 1'b1;
                    next_waddr     = pv_reg;
                    next_wdata     = nx_reg;
                    prev_waddr     = nx_reg;
                    prev_wdata     = pv_reg;
                    if (head_reg == idx_reg)
                    begin
                        head_next = nx_reg;
                    end
                    if (tail_reg == idx_reg)
                    begin
                        tail_next = pv_reg;
                    end
                    if (present_reg && cur_reg == idx_reg)
                    begin
                        // current leaves: successor takes over, fetch its id
                        cur_next   = nx_reg;
                        raddr      = nx_reg;
                        state_next = S_REM_CURID;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_REM_CURID:
            begin
                raddr       = cur_reg;
                cur_id_next = rd_id;
                finish      = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result register; hold the last step while the old result waits
        out_valid_next = out_valid_reg && out_stall;
        out_id_next    = out_id_reg;
        out_run_next   = out_run_reg;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;
        if (finish)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_run_next   = present_next;
                out_id_next    = present_next ? cur_id_next : 32'd0;
                out_st_next    = st_next;
                out_cnt_next   = count_next;
                state_next     = S_IDLE;
            end
            else
            begin
                // retry next cycle from a stable point
                state_next   = state_reg;
                active_next  = cfg_valid ? cfg_data : active_reg;
                begun_next   = begun_reg;
                present_next = present_reg;
                cur_next     = cur_reg;
                cur_id_next  = cur_id_reg;
                head_next    = head_reg;
                tail_next    = tail_reg;
                count_next   = count_reg;
                free_next    = free_reg;
                idx_next     = idx_reg;
                n_next       = n_reg;
                nx_next      = nx_reg;
                pv_next      = pv_reg;
                id_next      = id_reg;
                st_next      = st_reg;
                mem_we       = '0;
                if (state_reg == S_IDLE)
                begin
                    // request not taken yet
                    state_next = S_IDLE;
                end
            end
        end
    end

endmodule
